### hw/rtl/selm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package selm_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;

    localparam int COORD_W = 8;                    // pixel_x / pixel_y
    localparam int GRID_W  = 9;                    // grid registers, holds up to 511
    localparam int ROW_AW  = $clog2(MAX_HEIGHT);   // bitmap row address
    localparam int ROW_BITS = MAX_WIDTH;           // one bitmap row per word
    localparam int IDX_W   = 18;
    localparam int MARK_W  = 2;
    localparam int MUL_A_W = 10;
    localparam int MUL_B_W = 9;

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic CFG_GRID_WIDTH  = 1'b0;
    localparam logic CFG_GRID_HEIGHT = 1'b1;

    localparam logic [MARK_W-1:0] MARK_ZERO = 2'b00;
    localparam logic [MARK_W-1:0] MARK_POS  = 2'b01;
    localparam logic [MARK_W-1:0] MARK_NEG  = 2'b11;

    // operands for the shared multiply-add: a * b + c
    typedef struct packed {
        logic [MUL_A_W-1:0] mul_a;
        logic [MUL_B_W-1:0] mul_b;
        logic [COORD_W-1:0] add_c;
    } t_mac_req;

endpackage

`default_nettype wire

### hw/rtl/selm_bitmap.sv
`timescale 1ns / 1ps
`default_nettype none

module selm_bitmap (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [selm_pkg::ROW_AW-1:0]   i_rd_addr,
    output logic      [selm_pkg::ROW_BITS-1:0] o_rd_data,
    input  wire logic                          i_wr_en,
    input  wire logic [selm_pkg::ROW_AW-1:0]   i_wr_addr,
    input  wire logic [selm_pkg::ROW_BITS-1:0] i_wr_data,
    output logic                               o_busy
);

    logic [selm_pkg::ROW_BITS-1:0] r_mem [selm_pkg::MAX_HEIGHT];
    logic [selm_pkg::ROW_BITS-1:0] r_rd_data;
    logic [selm_pkg::ROW_AW:0]     r_clr_cnt;

    assign o_busy    = !r_clr_cnt[selm_pkg::ROW_AW];
    assign o_rd_data = r_rd_data;

    // clearing pass: one row per cycle after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (o_busy) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_busy) begin
            r_mem[r_clr_cnt[selm_pkg::ROW_AW-1:0]] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

### hw/rtl/selm_mac.sv
`timescale 1ns / 1ps
`default_nettype none

module selm_mac (
    input  wire logic                       i_clk,
    input  wire selm_pkg::t_mac_req         i_req,
    output logic [selm_pkg::IDX_W-1:0]      o_res
);

    localparam int PROD_W = selm_pkg::MUL_A_W + selm_pkg::MUL_B_W;

    logic [PROD_W-1:0]         w_prod;
    logic [PROD_W-1:0]         w_sum;
    logic [selm_pkg::IDX_W-1:0] r_res;

    assign w_prod = PROD_W'(i_req.mul_a) * PROD_W'(i_req.mul_b);
    assign w_sum  = w_prod + PROD_W'(i_req.add_c);
    assign o_res  = r_res;

    always_ff @(posedge i_clk) begin
        r_res <= w_sum[selm_pkg::IDX_W-1:0];
    end

endmodule

`default_nettype wire

### hw/rtl/selection_outline_edge_marker_core.sv
// Path: an item whose pixel changes inside the grid takes 3 bitmap row reads (S_CUR, S_UP,
// S_DN), then 4 passes through the shared multiply-add (S_MUL), then S_DONE; any other item
// goes from S_CUR straight to S_DONE. Items: one at a time, a new one is accepted only back
// in S_IDLE; set by the single bitmap read port and the one multiply-add unit.
// Reset: synchronous active low; the bitmap is cleared one row per cycle, and no item
// is accepted until every row is cleared. Grid registers reset to 256.
`timescale 1ns / 1ps
`default_nettype none

module selection_outline_edge_marker_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [0:0]                          i_cfg_idx,
    input  wire logic [selm_pkg::GRID_W-1:0]         i_cfg_data,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic                                i_cmd,
    input  wire logic [selm_pkg::COORD_W-1:0]        i_pixel_x,
    input  wire logic [selm_pkg::COORD_W-1:0]        i_pixel_y,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic                                     o_changed,
    output logic                                     o_edges_written,
    output logic        [selm_pkg::IDX_W-1:0]        o_left_index,
    output logic signed [selm_pkg::MARK_W-1:0]       o_left_mark,
    output logic        [selm_pkg::IDX_W-1:0]        o_right_index,
    output logic signed [selm_pkg::MARK_W-1:0]       o_right_mark,
    output logic        [selm_pkg::IDX_W-1:0]        o_top_index,
    output logic signed [selm_pkg::MARK_W-1:0]       o_top_mark,
    output logic        [selm_pkg::IDX_W-1:0]        o_bottom_index,
    output logic signed [selm_pkg::MARK_W-1:0]       o_bottom_mark
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CUR  = 3'd1;
    localparam logic [2:0] S_UP   = 3'd2;
    localparam logic [2:0] S_DN   = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    localparam int CW = selm_pkg::COORD_W;
    localparam int GW = selm_pkg::GRID_W;
    localparam int AW = selm_pkg::MUL_A_W;
    localparam int XW = $clog2(selm_pkg::ROW_BITS);

    logic [2:0]     r_state, n_state;
    logic [2:0]     r_step;
    logic [GW-1:0]  r_grid_w, r_grid_h;
    logic           r_cmd;
    logic [CW-1:0]  r_x, r_y;
    logic [GW-1:0]  r_w, r_h, r_c, r_r;
    logic           r_changed, r_edges;
    logic           r_nl, r_nr, r_nt, r_nb;
    logic [selm_pkg::IDX_W-1:0] r_top_idx, r_bot_idx, r_left_idx, r_right_idx;

    logic           r_out_valid;
    logic           r_o_changed, r_o_edges;
    logic [selm_pkg::IDX_W-1:0]  r_o_left_idx, r_o_right_idx, r_o_top_idx, r_o_bot_idx;
    logic [selm_pkg::MARK_W-1:0] r_o_left_mk, r_o_right_mk, r_o_top_mk, r_o_bot_mk;

    logic                            w_accept;
    logic                            w_busy;
    logic [selm_pkg::ROW_AW-1:0]     w_rd_addr;
    logic [selm_pkg::ROW_BITS-1:0]   w_row;
    logic                            w_wr_en;
    logic [selm_pkg::ROW_BITS-1:0]   w_wr_data;
    logic                            w_cur_bit;
    logic                            w_want;
    logic                            w_in_grid;
    logic                            w_load;
    logic [GW-1:0]                   w_sat_w, w_sat_h;
    selm_pkg::t_mac_req              w_mac_req;
    logic [selm_pkg::IDX_W-1:0]      w_mac_res;
    logic [selm_pkg::MARK_W-1:0]     w_ml, w_mr, w_mt, w_mb;

    assign o_ready  = (r_state == S_IDLE) && !w_busy;
    assign w_accept = i_valid && o_ready;
    assign w_load   = (r_state == S_DONE) && (!r_out_valid || i_ready);

    assign w_sat_w = (r_grid_w > GW'(selm_pkg::MAX_WIDTH))  ? GW'(selm_pkg::MAX_WIDTH)  : r_grid_w;
    assign w_sat_h = (r_grid_h > GW'(selm_pkg::MAX_HEIGHT)) ? GW'(selm_pkg::MAX_HEIGHT) : r_grid_h;

    assign w_cur_bit = w_row[r_x[XW-1:0]];
    assign w_want    = (r_cmd == selm_pkg::CMD_ADD);
    assign w_in_grid = (GW'(r_x) < r_w) && (GW'(r_y) < r_h);

    always_comb begin
        unique case (r_state)
            S_IDLE:  w_rd_addr = i_pixel_y;
            S_CUR:   w_rd_addr = r_y - 1'b1;
            S_UP:    w_rd_addr = r_y + 1'b1;
            default: w_rd_addr = r_y;
        endcase
    end

    always_comb begin
        w_wr_data = w_row;
        w_wr_data[r_x[XW-1:0]] = w_want;
        w_wr_en = (r_state == S_CUR) && (w_cur_bit != w_want);
    end

    selm_bitmap u_bitmap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_row),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_y),
        .i_wr_data (w_wr_data),
        .o_busy    (w_busy)
    );

    // top = y*C + x, bottom = (y+1)*C + x, left = (x+C)*R + y, right = (x+1+C)*R + y
    always_comb begin
        case (r_step[1:0])
            2'd0: begin
                w_mac_req.mul_a = AW'(r_y);
                w_mac_req.mul_b = r_c;
                w_mac_req.add_c = r_x;
            end
            2'd1: begin
                w_mac_req.mul_a = AW'(r_y) + AW'(1);
                w_mac_req.mul_b = r_c;
                w_mac_req.add_c = r_x;
            end
            2'd2: begin
                w_mac_req.mul_a = AW'(r_x) + AW'(r_c);
                w_mac_req.mul_b = r_r;
                w_mac_req.add_c = r_y;
            end
            default: begin
                w_mac_req.mul_a = AW'(r_x) + AW'(r_c) + AW'(1);
                w_mac_req.mul_b = r_r;
                w_mac_req.add_c = r_y;
            end
        endcase
    end

    selm_mac u_mac (
        .i_clk (i_clk),
        .i_req (w_mac_req),
        .o_res (w_mac_res)
    );

    always_comb begin
        if (r_cmd == selm_pkg::CMD_ADD) begin
            w_ml = r_nl ? selm_pkg::MARK_ZERO : selm_pkg::MARK_POS;
            w_mr = r_nr ? selm_pkg::MARK_ZERO : selm_pkg::MARK_NEG;
            w_mt = r_nt ? selm_pkg::MARK_ZERO : selm_pkg::MARK_NEG;
            w_mb = r_nb ? selm_pkg::MARK_ZERO : selm_pkg::MARK_POS;
        end else begin
            w_ml = r_nl ? selm_pkg::MARK_NEG : selm_pkg::MARK_ZERO;
            w_mr = r_nr ? selm_pkg::MARK_POS : selm_pkg::MARK_ZERO;
            w_mt = r_nt ? selm_pkg::MARK_POS : selm_pkg::MARK_ZERO;
            w_mb = r_nb ? selm_pkg::MARK_NEG : selm_pkg::MARK_ZERO;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = S_CUR;
            S_CUR: begin
                if (w_cur_bit == w_want || !w_in_grid) n_state = S_DONE;
                else                                   n_state = S_UP;
            end
            S_UP:   n_state = S_DN;
            S_DN:   n_state = S_MUL;
            S_MUL:  if (r_step == 3'd4) n_state = S_DONE;
            S_DONE: if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_grid_w    <= GW'(256);
            r_grid_h    <= GW'(256);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx[0])
                    selm_pkg::CFG_GRID_WIDTH:  r_grid_w <= i_cfg_data;
                    selm_pkg::CFG_GRID_HEIGHT: r_grid_h <= i_cfg_data;
                endcase
            end
            if (w_load)       r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_cmd;
            r_x   <= i_pixel_x;
            r_y   <= i_pixel_y;
            r_w   <= w_sat_w;
            r_h   <= w_sat_h;
            r_c   <= w_sat_w + 1'b1;
            r_r   <= w_sat_h + 1'b1;
        end
        case (r_state)
            S_CUR: begin
                r_changed <= (w_cur_bit != w_want);
                r_edges   <= (w_cur_bit != w_want) && w_in_grid;
                r_nl      <= (r_x != '0) && w_row[r_x[XW-1:0] - 1'b1];
                // x+1 wraps at the last column; the grid compare masks it
                r_nr      <= ((GW'(r_x) + 1'b1) < r_w) && w_row[r_x[XW-1:0] + 1'b1];
            end
            S_UP: r_nt <= (r_y != '0) && w_cur_bit;
            S_DN: begin
                r_nb   <= ((GW'(r_y) + 1'b1) < r_h) && w_cur_bit;
                r_step <= '0;
            end
            S_MUL: begin
                r_step <= r_step + 1'b1;
                case (r_step)
                    3'd1: r_top_idx   <= w_mac_res;
                    3'd2: r_bot_idx   <= w_mac_res;
                    3'd3: r_left_idx  <= w_mac_res;
                    3'd4: r_right_idx <= w_mac_res;
                    default: ;
                endcase
            end
            default: ;
        endcase
        if (w_load) begin
            r_o_changed   <= r_changed;
            r_o_edges     <= r_edges;
            r_o_left_idx  <= r_edges ? r_left_idx  : '0;
            r_o_right_idx <= r_edges ? r_right_idx : '0;
            r_o_top_idx   <= r_edges ? r_top_idx   : '0;
            r_o_bot_idx   <= r_edges ? r_bot_idx   : '0;
            r_o_left_mk   <= r_edges ? w_ml : selm_pkg::MARK_ZERO;
            r_o_right_mk  <= r_edges ? w_mr : selm_pkg::MARK_ZERO;
            r_o_top_mk    <= r_edges ? w_mt : selm_pkg::MARK_ZERO;
            r_o_bot_mk    <= r_edges ? w_mb : selm_pkg::MARK_ZERO;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_changed       = r_o_changed;
    assign o_edges_written = r_o_edges;
    assign o_left_index    = r_o_left_idx;
    assign o_left_mark     = r_o_left_mk;
    assign o_right_index   = r_o_right_idx;
    assign o_right_mark    = r_o_right_mk;
    assign o_top_index     = r_o_top_idx;
    assign o_top_mark      = r_o_top_mk;
    assign o_bottom_index  = r_o_bot_idx;
    assign o_bottom_mark   = r_o_bot_mk;

    a_no_edges_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_edges_written) |-> (o_left_index == '0 && o_right_index == '0 &&
            o_top_index == '0 && o_bottom_index == '0 && o_left_mark == '0 &&
            o_right_mark == '0 && o_top_mark == '0 && o_bottom_mark == '0))
        else $error("edge fields set without edge updates");

    a_edges_need_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_edges_written) |-> o_changed)
        else $error("edge updates without a change");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_ready)
        else $error("second item taken while one is in work");

    a_no_accept_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !w_accept && !w_wr_en)
        else $error("bitmap used during clearing pass");

    a_mark_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_left_mark != 2'b10 && o_right_mark != 2'b10 &&
            o_top_mark != 2'b10 && o_bottom_mark != 2'b10))
        else $error("invalid marker code");

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int COORD_W    = selm_pkg::COORD_W;
    localparam int GRID_W     = selm_pkg::GRID_W;
    localparam int IDX_W      = selm_pkg::IDX_W;
    localparam int MARK_W     = selm_pkg::MARK_W;
    localparam int MAX_WIDTH  = selm_pkg::MAX_WIDTH;
    localparam int MAX_HEIGHT = selm_pkg::MAX_HEIGHT;

    typedef struct packed {
        logic               cmd;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_edit;

    typedef struct packed {
        logic              changed;
        logic              edges_written;
        logic [IDX_W-1:0]  left_index;
        logic [MARK_W-1:0] left_mark;
        logic [IDX_W-1:0]  right_index;
        logic [MARK_W-1:0] right_mark;
        logic [IDX_W-1:0]  top_index;
        logic [MARK_W-1:0] top_mark;
        logic [IDX_W-1:0]  bottom_index;
        logic [MARK_W-1:0] bottom_mark;
    } t_outline;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [0:0]          i_cfg_idx = selm_pkg::CFG_GRID_WIDTH;
    logic [GRID_W-1:0]   i_cfg_data = '0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic                i_cmd = selm_pkg::CMD_ADD;
    logic [COORD_W-1:0]  i_pixel_x = '0;
    logic [COORD_W-1:0]  i_pixel_y = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic                o_changed;
    logic                o_edges_written;
    logic [IDX_W-1:0]    o_left_index;
    logic [MARK_W-1:0]   o_left_mark;
    logic [IDX_W-1:0]    o_right_index;
    logic [MARK_W-1:0]   o_right_mark;
    logic [IDX_W-1:0]    o_top_index;
    logic [MARK_W-1:0]   o_top_mark;
    logic [IDX_W-1:0]    o_bottom_index;
    logic [MARK_W-1:0]   o_bottom_mark;

    selection_outline_edge_marker_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_cmd           (i_cmd),
        .i_pixel_x       (i_pixel_x),
        .i_pixel_y       (i_pixel_y),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_changed       (o_changed),
        .o_edges_written (o_edges_written),
        .o_left_index    (o_left_index),
        .o_left_mark     (o_left_mark),
        .o_right_index   (o_right_index),
        .o_right_mark    (o_right_mark),
        .o_top_index     (o_top_index),
        .o_top_mark      (o_top_mark),
        .o_bottom_index  (o_bottom_index),
        .o_bottom_mark   (o_bottom_mark)
    );

    // shadow of the selection bitmap and grid registers
    bit          sel_map [0:MAX_HEIGHT-1][0:MAX_WIDTH-1];
    int unsigned grid_w = 256;
    int unsigned grid_h = 256;

    t_edit    edit_queue[$];
    t_outline expected_outlines[$];

    int tx_idle_pct = 22;
    int rx_idle_pct = 60;
    logic rx_hold = 1'b0;
    int phase_num = -1;
    int err_count = 0;
    int n_outline = 0;
    int n_off_grid = 0;
    int n_unchanged = 0;
    int n_removes = 0;
    int n_results = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_outline apply_edit(input t_edit e);
        t_outline    r;
        int unsigned x, y, w, h, c, rows;
        logic        add, nl, nr, nt, nb;
        r = '0;
        x = e.x;
        y = e.y;
        add = (e.cmd == selm_pkg::CMD_ADD);
        if (sel_map[y][x] == add) begin
            n_unchanged++;
            return r;
        end
        sel_map[y][x] = add;
        r.changed = 1'b1;
        w = (grid_w > MAX_WIDTH) ? MAX_WIDTH : grid_w;
        h = (grid_h > MAX_HEIGHT) ? MAX_HEIGHT : grid_h;
        if (x >= w || y >= h) begin
            n_off_grid++;
            return r;
        end
        n_outline++;
        nl = (x > 0) && sel_map[y][x-1];
        nr = (x + 1 < w) && sel_map[y][x+1];
        nt = (y > 0) && sel_map[y-1][x];
        nb = (y + 1 < h) && sel_map[y+1][x];
        if (add) begin
            r.left_mark   = nl ? selm_pkg::MARK_ZERO : selm_pkg::MARK_POS;
            r.right_mark  = nr ? selm_pkg::MARK_ZERO : selm_pkg::MARK_NEG;
            r.top_mark    = nt ? selm_pkg::MARK_ZERO : selm_pkg::MARK_NEG;
            r.bottom_mark = nb ? selm_pkg::MARK_ZERO : selm_pkg::MARK_POS;
        end else begin
            r.left_mark   = nl ? selm_pkg::MARK_NEG : selm_pkg::MARK_ZERO;
            r.right_mark  = nr ? selm_pkg::MARK_POS : selm_pkg::MARK_ZERO;
            r.top_mark    = nt ? selm_pkg::MARK_POS : selm_pkg::MARK_ZERO;
            r.bottom_mark = nb ? selm_pkg::MARK_NEG : selm_pkg::MARK_ZERO;
        end
        c = w + 1;
        rows = h + 1;
        r.edges_written = 1'b1;
        r.left_index    = IDX_W'(y + (x + c) * rows);
        r.right_index   = IDX_W'(y + (x + 1 + c) * rows);
        r.top_index     = IDX_W'(y * c + x);
        r.bottom_index  = IDX_W'((y + 1) * c + x);
        return r;
    endfunction

    task automatic report_error(input string msg);
        err_count++;
        if (err_count <= 40)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [IDX_W-1:0] got,
                               input logic [IDX_W-1:0] want);
        if (got !== want)
            report_error($sformatf("result %0d %s got 0x%0h want 0x%0h",
                                   n_results, name, got, want));
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                expected_outlines.push_back(apply_edit('{i_cmd, i_pixel_x, i_pixel_y}));
                if (i_cmd == selm_pkg::CMD_REMOVE) n_removes++;
            end
            if (!i_valid || o_ready) begin
                if (edit_queue.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                    i_valid   <= 1'b1;
                    i_cmd     <= edit_queue[0].cmd;
                    i_pixel_x <= edit_queue[0].x;
                    i_pixel_y <= edit_queue[0].y;
                    void'(edit_queue.pop_front());
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_outline want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_outlines.size() == 0) begin
                report_error("result with no edit outstanding");
            end else begin
                want = expected_outlines.pop_front();
                check_field("changed", IDX_W'(o_changed), IDX_W'(want.changed));
                check_field("edges_written", IDX_W'(o_edges_written),
                            IDX_W'(want.edges_written));
                check_field("left_index", o_left_index, want.left_index);
                check_field("left_mark", IDX_W'(o_left_mark), IDX_W'(want.left_mark));
                check_field("right_index", o_right_index, want.right_index);
                check_field("right_mark", IDX_W'(o_right_mark), IDX_W'(want.right_mark));
                check_field("top_index", o_top_index, want.top_index);
                check_field("top_mark", IDX_W'(o_top_mark), IDX_W'(want.top_mark));
                check_field("bottom_index", o_bottom_index, want.bottom_index);
                check_field("bottom_mark", IDX_W'(o_bottom_mark), IDX_W'(want.bottom_mark));
            end
            n_results++;
        end
        i_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    // long receiver hold-off so the block backs up and stalls its input
    initial begin
        wait (phase_num == 5);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (300) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic push_edit(input logic cmd, input int x, input int y);
        edit_queue.push_back('{cmd, COORD_W'(x), COORD_W'(y)});
    endtask

    task automatic write_grid(input logic [0:0] idx, input int unsigned value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= GRID_W'(value);
        if (idx == selm_pkg::CFG_GRID_WIDTH) grid_w = value;
        else grid_h = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // wait until every queued edit is out and every result is back
    task automatic drain();
        @(posedge i_clk);
        while (edit_queue.size() > 0 || i_valid || expected_outlines.size() > 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic set_grid(input int unsigned w, input int unsigned h);
        write_grid(selm_pkg::CFG_GRID_WIDTH, w);
        write_grid(selm_pkg::CFG_GRID_HEIGHT, h);
    endtask

    task automatic fill_random(input int n);
        int unsigned ew, eh;
        int cx, cy, x, y;
        ew = (grid_w > MAX_WIDTH) ? MAX_WIDTH : grid_w;
        eh = (grid_h > MAX_HEIGHT) ? MAX_HEIGHT : grid_h;
        cx = 0;
        cy = 0;
        for (int i = 0; i < n; i++) begin
            // dense 8x8 windows so neighbors are often selected
            if (i % 32 == 0) begin
                case ($urandom_range(2))
                    0: begin
                        cx = 0;
                        cy = 0;
                    end
                    1: begin
                        cx = (int'(ew) - 4 < 0) ? 0 : (int'(ew) - 4 > 248) ? 248 : int'(ew) - 4;
                        cy = (int'(eh) - 4 < 0) ? 0 : (int'(eh) - 4 > 248) ? 248 : int'(eh) - 4;
                    end
                    default: begin
                        cx = $urandom_range(248);
                        cy = $urandom_range(248);
                    end
                endcase
            end
            if ($urandom_range(99) < 75) begin
                x = cx + $urandom_range(7);
                y = cy + $urandom_range(7);
            end else begin
                x = $urandom_range(255);
                y = $urandom_range(255);
            end
            push_edit($urandom_range(1) ? selm_pkg::CMD_REMOVE : selm_pkg::CMD_ADD, x, y);
        end
    endtask

    initial begin
        int unsigned pw [12];
        int unsigned ph [12];
        pw = '{256, 1, 8, 5, 511, 2, 16, 300, 0, 257, 0, 0};
        ph = '{256, 1, 8, 12, 511, 257, 4, 7, 0, 1, 0, 0};
        pw[10] = $urandom_range(1, 64);
        ph[10] = $urandom_range(1, 64);
        pw[11] = $urandom_range(1, 256);
        ph[11] = $urandom_range(1, 256);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // bitmap clear runs after reset; ready comes back when it is done
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);

        // corners, no-change, full neighborhoods at reset grid size
        @(negedge i_clk);
        push_edit(selm_pkg::CMD_ADD, 0, 0);
        push_edit(selm_pkg::CMD_ADD, 0, 0);
        push_edit(selm_pkg::CMD_ADD, 255, 255);
        push_edit(selm_pkg::CMD_ADD, 255, 0);
        push_edit(selm_pkg::CMD_ADD, 0, 255);
        push_edit(selm_pkg::CMD_ADD, 1, 0);
        push_edit(selm_pkg::CMD_REMOVE, 7, 7);
        push_edit(selm_pkg::CMD_ADD, 10, 9);
        push_edit(selm_pkg::CMD_ADD, 9, 10);
        push_edit(selm_pkg::CMD_ADD, 11, 10);
        push_edit(selm_pkg::CMD_ADD, 10, 11);
        push_edit(selm_pkg::CMD_ADD, 10, 10);
        push_edit(selm_pkg::CMD_REMOVE, 10, 10);
        push_edit(selm_pkg::CMD_REMOVE, 0, 0);
        push_edit(selm_pkg::CMD_REMOVE, 255, 255);
        drain();

        // small grid: pixels past the grid edge are stored with no outline
        set_grid(3, 2);
        @(negedge i_clk);
        push_edit(selm_pkg::CMD_ADD, 2, 1);
        push_edit(selm_pkg::CMD_ADD, 3, 1);
        push_edit(selm_pkg::CMD_ADD, 170, 85);
        push_edit(selm_pkg::CMD_ADD, 1, 1);
        push_edit(selm_pkg::CMD_REMOVE, 3, 1);
        drain();

        // zero grid: nothing is inside
        set_grid(0, 0);
        @(negedge i_clk);
        push_edit(selm_pkg::CMD_ADD, 4, 4);
        push_edit(selm_pkg::CMD_REMOVE, 1, 0);
        drain();

        // oversize registers saturate to the bitmap size
        set_grid(511, 511);
        @(negedge i_clk);
        push_edit(selm_pkg::CMD_ADD, 255, 254);
        push_edit(selm_pkg::CMD_ADD, 254, 255);
        drain();

        for (int p = 0; p < 12; p++) begin
            if (p < 4) begin
                tx_idle_pct = 22;
                rx_idle_pct = 60;
            end else if (p < 8) begin
                tx_idle_pct = 60;
                rx_idle_pct = 22;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            set_grid(pw[p], ph[p]);
            phase_num = p;
            @(negedge i_clk);
            fill_random(155);
            drain();
        end

        if (expected_outlines.size() > 0)
            report_error($sformatf("%0d results never arrived", expected_outlines.size()));
        $display("Ran %0d edits (%0d removes) over 16 grid settings incl. zero and oversize.",
                 n_results, n_removes);
        $display("%0d with outline updates, %0d off-grid changes, %0d without change.",
                 n_outline, n_off_grid, n_unchanged);
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### selection_outline_edge_marker_core.f
hw/rtl/selm_pkg.sv
hw/rtl/selm_bitmap.sv
hw/rtl/selm_mac.sv
hw/rtl/selection_outline_edge_marker_core.sv
tb/tb.sv
